>>> rtl/scc_pkg.sv
// types, constants and helper functions shared by the color cell splitter
// no dependencies; imported by scc_front, scc_queue, scc_back and the top level
package scc_pkg;

   localparam logic [7:0] ESC_CODE  = 8'h1B;
   localparam logic [7:0] CHAR_LBRK = 8'h5B;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [9:0] PARAM_MAX    = 10'd1023;
   localparam logic [9:0] SGR_RESET    = 10'd0;
   localparam logic [9:0] SGR_NORMAL   = 10'd22;
   localparam logic [9:0] SGR_FG_LO    = 10'd30;
   localparam logic [9:0] SGR_FG_HI    = 10'd37;
   localparam logic [9:0] SGR_FG_DEF   = 10'd39;
   localparam logic [9:0] SGR_FG_BR_LO = 10'd90;
   localparam logic [9:0] SGR_FG_BR_HI = 10'd97;

   localparam logic KIND_CELL = 1'b0;
   localparam logic KIND_ROW  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] cell_bytes;
      logic [2:0]  cell_len;
      logic [6:0]  color;
      logic [7:0]  column;
      logic [8:0]  row_cells;
      logic [8:0]  widest;
      logic        color_seen;
   } result_type;

   // up to three results caused by one request
   typedef struct packed {
      logic [1:0]            count;
      result_type [2:0]      res;
   } bundle_type;

   function automatic logic is_color_code(logic [9:0] v);
      return ((v >= SGR_FG_LO) && (v <= SGR_FG_HI)) || (v == SGR_FG_DEF) ||
             ((v >= SGR_FG_BR_LO) && (v <= SGR_FG_BR_HI));
   endfunction

   // color after a sequence ends
   function automatic logic [6:0] end_color(logic present, logic [9:0] v,
                                            logic [6:0] cur);
      logic [6:0] c;
      c = cur;
      if (present) begin
         if (is_color_code(v)) c = v[6:0];
         if (v == SGR_RESET) c = 7'd0;
      end
      return c;
   endfunction

   // color after a separator
   function automatic logic [6:0] sep_color(logic present, logic [9:0] v,
                                            logic [6:0] cur);
      logic [6:0] c;
      c = cur;
      if (present) begin
         if (is_color_code(v)) c = v[6:0];
         if ((v == SGR_RESET) || (v == SGR_NORMAL)) c = 7'd0;
      end
      return c;
   endfunction

   function automatic logic [2:0] lead_length(logic [7:0] b);
      logic [2:0] len;
      if (b[7] == 1'b0)             len = 3'd1;
      else if (b[7:5] == 3'b110)    len = 3'd2;
      else if (b[7:4] == 4'b1110)   len = 3'd3;
      else if (b[7:3] == 5'b11110)  len = 3'd4;
      else                          len = 3'd1;
      return len;
   endfunction

endpackage

>>> rtl/sgr_color_cell_splitter_core.sv
// top level of the color cell splitter: text bytes in, colored display cells out
// instantiates scc_front, scc_queue and scc_back; uses scc_pkg
//
// usage
// - request channel: one text byte per request (tdata), tuser bit 0 says the
//   byte is present, tuser bit 1 starts a new image, tlast closes the row
// - response channel: one cell or one row summary per response; tuser is the
//   kind (0 cell, 1 row summary), tlast marks the final response of a request
// - a request gives zero to three responses; escape sequences give none
// - the first response of a request is held in a queue entry, then in the response register
// - throughput: one request per cycle while req_tready is high; responses leave one per
//   cycle while rsp_tready is high, so a burst of requests with several responses each is paced by the response port
// - the front end decodes a request combinationally into a bundle, a
//   four-entry queue holds bundles, the back end drains them through a register
// - when the receiver stalls the response register holds; requests keep being
//   taken until the queue fills, then req_tready drops
// - reset (synchronous) clears all parser, row and image state; no warm-up pass
module sgr_color_cell_splitter_core #(
   parameter int MAX_COLS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic [1:0]  req_tuser,   // byte_valid, image_start
   input  logic        req_tlast,   // row_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // cell_bytes, cell_len, color, column, row_cells,
                                    // widest, color_seen, zero pad
   output logic        rsp_tuser,   // kind
   output logic        rsp_tlast    // last
);
   import scc_pkg::*;

   logic       take;
   logic       push;
   logic       pop;
   logic       full;
   logic       empty;
   bundle_type bundle;
   bundle_type head;
   result_type out_data;

   assign req_tready = !full;
   assign take       = req_tvalid && req_tready;

   scc_front #(
      .MAX_COLS(MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .data_byte  (req_tdata),
      .byte_valid (req_tuser[0]),
      .row_end    (req_tlast),
      .image_start(req_tuser[1]),
      .push       (push),
      .bundle     (bundle)
   );

   scc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(bundle),
      .pop      (pop),
      .full     (full),
      .empty    (empty),
      .head     (head)
   );

   scc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .empty    (empty),
      .head     (head),
      .pop      (pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (out_data),
      .out_last (rsp_tlast)
   );

   assign rsp_tuser = out_data.kind;
   assign rsp_tdata = {3'b000, out_data.color_seen, out_data.widest, out_data.row_cells,
                       out_data.column, out_data.color, out_data.cell_len,
                       out_data.cell_bytes};

endmodule

>>> rtl/scc_front.sv
// front end: escape parsing, utf-8 gathering and row bookkeeping
// produces one bundle of up to three results per request; uses scc_pkg
module scc_front #(
   parameter int MAX_COLS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  logic [7:0]         data_byte,
   input  logic               byte_valid,
   input  logic               row_end,
   input  logic               image_start,
   output logic               push,
   output scc_pkg::bundle_type bundle
);
   import scc_pkg::*;

   localparam int CW = $clog2(MAX_COLS + 1);
   localparam logic [CW-1:0] MAX_C = CW'(MAX_COLS);

   logic          esc_pending_ff, esc_pending_in;
   logic          in_params_ff, in_params_in;
   logic [9:0]    param_value_ff, param_value_in;
   logic          param_present_ff, param_present_in;
   logic [6:0]    color_ff, color_in;
   logic [31:0]   gather_bytes_ff, gather_bytes_in;
   logic [2:0]    gather_count_ff, gather_count_in;
   logic [2:0]    gather_need_ff, gather_need_in;
   logic [CW-1:0] column_ff, column_in;
   logic [CW-1:0] widest_ff, widest_in;
   logic          any_color_ff, any_color_in;

   function automatic result_type make_cell(logic [31:0] bytes, logic [2:0] len,
                                            logic [6:0] color, logic [CW-1:0] col,
                                            logic [CW-1:0] wid, logic anyc);
      result_type r;
      r.kind       = KIND_CELL;
      r.cell_bytes = bytes;
      r.cell_len   = len;
      r.color      = color;
      r.column     = 8'(col);
      r.row_cells  = 9'd0;
      r.widest     = 9'(wid);
      r.color_seen = anyc;
      return r;
   endfunction

   always_comb begin
      logic [1:0]  n;
      logic        skip;
      logic [7:0]  b;
      logic [2:0]  len;
      logic [13:0] v;
      result_type  summary;

      esc_pending_in   = esc_pending_ff;
      in_params_in     = in_params_ff;
      param_value_in   = param_value_ff;
      param_present_in = param_present_ff;
      color_in         = color_ff;
      gather_bytes_in  = gather_bytes_ff;
      gather_count_in  = gather_count_ff;
      gather_need_in   = gather_need_ff;
      column_in        = column_ff;
      widest_in        = widest_ff;
      any_color_in     = any_color_ff;
      n                = 2'd0;
      skip             = 1'b0;
      b                = data_byte;
      len              = 3'd0;
      v                = 14'd0;
      summary          = '0;
      bundle           = '0;

      if (image_start) begin
         widest_in    = '0;
         any_color_in = 1'b0;
      end

      if (byte_valid && (column_in < MAX_C)) begin
         if (gather_need_in != 3'd0) begin
            gather_bytes_in = gather_bytes_in |
                              (32'(b) << {gather_count_in[1:0], 3'b000});
            gather_count_in = gather_count_in + 3'd1;
            if (gather_count_in >= gather_need_in) begin
               if (column_in < MAX_C) begin
                  bundle.res[n] = make_cell(gather_bytes_in, gather_count_in, color_in,
                                            column_in, widest_in, any_color_in);
                  n = n + 2'd1;
                  column_in = column_in + CW'(1);
               end
               gather_bytes_in = '0;
               gather_count_in = '0;
               gather_need_in  = '0;
            end
         end else if (in_params_in) begin
            if ((b >= CHAR_ZERO) && (b <= CHAR_NINE)) begin
               v = 14'(param_value_in) * 14'd10 + 14'(b - CHAR_ZERO);
               param_value_in   = (v > 14'(PARAM_MAX)) ? PARAM_MAX : v[9:0];
               param_present_in = 1'b1;
            end else if (b == CHAR_SEMI) begin
               color_in = sep_color(param_present_in, param_value_in, color_in);
               param_value_in   = '0;
               param_present_in = 1'b0;
            end else begin
               color_in = end_color(param_present_in, param_value_in, color_in);
               in_params_in     = 1'b0;
               param_value_in   = '0;
               param_present_in = 1'b0;
               if (color_in != 7'd0) any_color_in = 1'b1;
            end
         end else begin
            if (esc_pending_in) begin
               esc_pending_in = 1'b0;
               if (b == CHAR_LBRK) begin
                  in_params_in     = 1'b1;
                  param_value_in   = '0;
                  param_present_in = 1'b0;
                  skip             = 1'b1;
               end else begin
                  if (column_in < MAX_C) begin
                     bundle.res[n] = make_cell(32'(ESC_CODE), 3'd1, color_in,
                                               column_in, widest_in, any_color_in);
                     n = n + 2'd1;
                     column_in = column_in + CW'(1);
                  end
                  if (column_in >= MAX_C) skip = 1'b1;
               end
            end
            if (!skip) begin
               if (b == ESC_CODE) begin
                  esc_pending_in = 1'b1;
               end else begin
                  len = lead_length(b);
                  if (len == 3'd1) begin
                     if (column_in < MAX_C) begin
                        bundle.res[n] = make_cell(32'(b), 3'd1, color_in,
                                                  column_in, widest_in, any_color_in);
                        n = n + 2'd1;
                        column_in = column_in + CW'(1);
                     end
                  end else begin
                     gather_bytes_in = 32'(b);
                     gather_count_in = 3'd1;
                     gather_need_in  = len;
                  end
               end
            end
         end
      end

      if (row_end) begin
         if (in_params_in) begin
            color_in = end_color(param_present_in, param_value_in, color_in);
            in_params_in     = 1'b0;
            param_value_in   = '0;
            param_present_in = 1'b0;
            if (color_in != 7'd0) any_color_in = 1'b1;
         end
         if (esc_pending_in) begin
            esc_pending_in = 1'b0;
            if (column_in < MAX_C) begin
               bundle.res[n] = make_cell(32'(ESC_CODE), 3'd1, color_in,
                                         column_in, widest_in, any_color_in);
               n = n + 2'd1;
               column_in = column_in + CW'(1);
            end
         end
         if (gather_need_in != 3'd0) begin
            if (column_in < MAX_C) begin
               bundle.res[n] = make_cell(gather_bytes_in, gather_count_in, color_in,
                                         column_in, widest_in, any_color_in);
               n = n + 2'd1;
               column_in = column_in + CW'(1);
            end
            gather_bytes_in = '0;
            gather_count_in = '0;
            gather_need_in  = '0;
         end
         if (column_in > widest_in) widest_in = column_in;
         summary.kind       = KIND_ROW;
         summary.row_cells  = 9'(column_in);
         summary.widest     = 9'(widest_in);
         summary.color_seen = any_color_in;
         bundle.res[n]      = summary;
         n = n + 2'd1;
         column_in        = '0;
         color_in         = 7'd0;
         esc_pending_in   = 1'b0;
         in_params_in     = 1'b0;
         param_value_in   = '0;
         param_present_in = 1'b0;
      end

      bundle.count = n;
   end

   assign push = take && (bundle.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_pending_ff   <= 1'b0;
         in_params_ff     <= 1'b0;
         param_value_ff   <= '0;
         param_present_ff <= 1'b0;
         color_ff         <= '0;
         gather_bytes_ff  <= '0;
         gather_count_ff  <= '0;
         gather_need_ff   <= '0;
         column_ff        <= '0;
         widest_ff        <= '0;
         any_color_ff     <= 1'b0;
      end else if (take) begin
         esc_pending_ff   <= esc_pending_in;
         in_params_ff     <= in_params_in;
         param_value_ff   <= param_value_in;
         param_present_ff <= param_present_in;
         color_ff         <= color_in;
         gather_bytes_ff  <= gather_bytes_in;
         gather_count_ff  <= gather_count_in;
         gather_need_ff   <= gather_need_in;
         column_ff        <= column_in;
         widest_ff        <= widest_in;
         any_color_ff     <= any_color_in;
      end
   end

endmodule

>>> rtl/scc_queue.sv
// four-entry bundle queue between front and back end
// uses scc_pkg for the bundle type
module scc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  scc_pkg::bundle_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output scc_pkg::bundle_type head
);
   import scc_pkg::*;

   localparam int DEPTH = 4;

   bundle_type entry_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] fill_ff, fill_in;

   assign full  = (fill_ff == 3'(DEPTH));
   assign empty = (fill_ff == 3'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (push ? 2'd1 : 2'd0);
      rd_ptr_in = rd_ptr_ff + (pop ? 2'd1 : 2'd0);
      fill_in   = fill_ff + (push ? 3'd1 : 3'd0) - (pop ? 3'd1 : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

>>> rtl/scc_back.sv
// back end: serializes queued bundles into single results on the output register
// uses scc_pkg for the bundle and result types
module scc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                empty,
   input  scc_pkg::bundle_type head,
   output logic                pop,
   output logic                out_valid,
   input  logic                out_ready,
   output scc_pkg::result_type out_data,
   output logic                out_last
);
   import scc_pkg::*;

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   logic       out_last_ff, out_last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       final_one;

   assign load      = !out_valid_ff || out_ready;
   assign final_one = (2'(idx_ff + 2'd1) == head.count);
   assign pop       = load && !empty && final_one;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      idx_in       = idx_ff;
      if (load) begin
         out_valid_in = !empty;
         if (!empty) begin
            out_data_in = head.res[idx_ff];
            out_last_in = final_one;
            idx_in      = final_one ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_last_ff  <= 1'b0;
         idx_ff       <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         out_last_ff  <= out_last_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign out_last  = out_last_ff;

endmodule
